[src/cross_average_half_downsample_assert.svh]
// Assertion macros for the cross average downsampler.
// Each macro checks one implication on the rising clock edge and stays quiet in reset.
`ifndef CROSS_AVERAGE_HALF_DOWNSAMPLE_ASSERT_SVH
`define CROSS_AVERAGE_HALF_DOWNSAMPLE_ASSERT_SVH

// Same-cycle implication.
`define CAH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("cross average downsample: assertion failed");

// Next-cycle implication.
`define CAH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("cross average downsample: assertion failed");

`endif

[src/cah_pkg.sv]
`default_nettype none

package cah_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;

  // Pixel and lane sizes
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int NUM_OPND = 5;
  localparam int SUM_W    = 11;

  // Reciprocals for the divide by 3, 4 and 5, scaled by 2^RECIP_SHIFT
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_3 = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_5 = 15'd13108;

  // Output queue
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef logic [CHAN_W-1:0] chan_t;
  // Index 2 is red, 1 green, 0 blue
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;
  typedef logic [NUM_OPND-1:0][CHAN_W-1:0] opnd_t;

  typedef enum logic [1:0] {
    DIV_3,
    DIV_4,
    DIV_5
  } div_e;

  // Which neighborhood an item completes
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_CROSS,
    SRC_LAST_EVEN,
    SRC_LAST_ODD
  } src_e;

  typedef struct packed {
    logic [9:0]  ox;
    logic [10:0] oy;
    logic        last;
  } pos_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    pos_t  pos;
  } out_item_t;

endpackage

`default_nettype wire

[src/cah_ram.sv]
`default_nettype none

module cah_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads return the contents before a same-edge write
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[src/cah_lane.sv]
`default_nettype none

module cah_lane (
  input  wire logic          clk_i,
  input  wire cah_pkg::opnd_t opnd_i,
  input  wire cah_pkg::div_e  div_i,
  output cah_pkg::chan_t      avg_o
);
  import cah_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]   sum_d;
  logic [SUM_W-1:0]   sum_q;
  div_e               div_q;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  // Add the five operands of this channel
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_OPND; i++) begin
      sum_d = sum_d + SUM_W'(opnd_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    div_q <= div_i;
  end

  // Divide by multiplying with the scaled reciprocal
  always_comb begin
    case (div_q)
      DIV_3:   recip = RECIP_3;
      DIV_5:   recip = RECIP_5;
      default: recip = RECIP_4;
    endcase
  end

  assign prod  = PROD_W'(sum_q) * PROD_W'(recip);
  assign avg_o = prod[RECIP_SHIFT +: CHAN_W];

endmodule

`default_nettype wire

[src/cah_ofifo.sv]
`default_nettype none

module cah_ofifo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  input  wire cah_pkg::out_item_t                  item_i,
  input  wire logic                                pop_i,
  output logic                                     valid_o,
  output cah_pkg::out_item_t                       item_o,
  output logic      [cah_pkg::OFIFO_CNT_W-1:0]     count_o
);
  import cah_pkg::*;

  out_item_t              entry_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr_q;
  logic [OFIFO_PTR_W-1:0] rd_ptr_q;
  logic [OFIFO_CNT_W-1:0] count_q;
  logic                   do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

[src/cross_average_half_downsample.sv]
// Throughput: one pixel item per clock. Input stall rises only when the four-entry output
// queue plus the results still in the two pipeline stages reach four.
// Path: an accepted item is registered into the cross stage (line-buffer read and cross sum),
// then the per-channel reciprocal multiply feeds the output queue that drives out_valid_o.
// Reset: position counters, recent pixels and the queue clear, registers return to 640 x 480;
// line buffers are left as they are and need no clearing pass.
`default_nettype none
`include "cross_average_half_downsample_assert.svh"

module cross_average_half_downsample (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  input  wire logic        frame_start_i,
  // Result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  red_out_o,
  output logic      [7:0]  green_out_o,
  output logic      [7:0]  blue_out_o,
  output logic      [9:0]  out_col_o,
  output logic      [10:0] out_row_o,
  output logic             frame_last_o
);
  import cah_pkg::*;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0] col;
    pix_t             px;
    pix_t             rec0;
    pix_t             rec1;
    src_e             src;
    div_e             div;
    pos_t             pos;
  } s1_t;

  // Configuration registers
  logic [CFG_W_W-1:0] image_width_q;
  logic [CFG_H_W-1:0] image_height_q;
  logic [CFG_W_W-1:0] w_cl;
  logic [CFG_H_W-1:0] h_cl;
  logic               cfg_wr;
  logic               reg_idx;

  // Position and recent pixels
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  pix_t             rec0_q, rec1_q;

  // Accept stage
  logic             in_accept;
  pix_t             px;
  logic [COL_W-1:0] c_base, c;
  logic [ROW_W-1:0] r_base, r;
  logic             wrap_col;
  logic [CFG_H_W-1:0] r_pre, r_inc;
  logic [CFG_W_W-1:0] c_inc;
  logic             last_row;
  src_e             s0_src;
  div_e             s0_div;
  pos_t             s0_pos;

  // Line buffer access
  pix_t ra_rd_a, ra_rd_b, rt_rd_a, rt_rd_b;
  logic             wr_v_q;
  logic [COL_W-1:0] wr_addr_q;
  pix_t             wr_px_q;
  pix_t             wr_ab_q;

  // Cross stage
  logic  s1_v_q;
  s1_t   s1_q;
  logic  s1_emit;
  pix_t  above_c, right_p, two_c, left_p;
  pix_t  op1, op2, op3, op4;
  opnd_t lane_opnd [NUM_CHAN];
  pix_t  lane_avg;

  // Divide stage and queue
  logic                   s2_v_q;
  pos_t                   s2_pos_q;
  out_item_t              push_item, head_item;
  logic [OFIFO_CNT_W-1:0] fifo_count;
  logic [OFIFO_CNT_W:0]   pending;

  // Register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = {20'd0, image_width_q};
      REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 12'd640;
      image_height_q <= 13'd480;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[CFG_H_W-1:0];
      endcase
    end
  end

  // Clamp the frame size to the supported range
  always_comb begin
    if (image_width_q < 12'd2) begin
      w_cl = 12'd2;
    end else if (image_width_q > CFG_W_W'(MAX_WIDTH)) begin
      w_cl = CFG_W_W'(MAX_WIDTH);
    end else begin
      w_cl = image_width_q;
    end
    if (image_height_q < 13'd2) begin
      h_cl = 13'd2;
    end else if (image_height_q > CFG_H_W'(MAX_HEIGHT)) begin
      h_cl = CFG_H_W'(MAX_HEIGHT);
    end else begin
      h_cl = image_height_q;
    end
  end

  // Hold off input while the queue could fill
  assign s1_emit    = s1_v_q && (s1_q.src != SRC_NONE);
  assign pending    = {1'b0, fifo_count} + (OFIFO_CNT_W+1)'(s1_emit)
                    + (OFIFO_CNT_W+1)'(s2_v_q);
  assign in_stall_o = (pending >= (OFIFO_CNT_W+1)'(OFIFO_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign px         = {red_in_i, green_in_i, blue_in_i};

  // Locate the item and decide which cross it completes
  always_comb begin
    c_base   = frame_start_i ? '0 : col_q;
    r_base   = frame_start_i ? '0 : row_q;
    wrap_col = ({1'b0, c_base} >= w_cl);
    r_pre    = {1'b0, r_base} + (wrap_col ? 13'd1 : 13'd0);
    c        = wrap_col ? '0 : c_base;
    r        = (r_pre >= h_cl) ? '0 : r_pre[ROW_W-1:0];
    c_inc    = {1'b0, c} + 12'd1;
    r_inc    = {1'b0, r} + 13'd1;

    if (c_inc >= w_cl) begin
      col_d = '0;
      row_d = (r_inc >= h_cl) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_d = c_inc[COL_W-1:0];
      row_d = r;
    end

    last_row = !h_cl[0] && ({1'b0, r} == h_cl - 13'd1);
    if (!r[0] && (r >= 12'd2) && c[0]) begin
      s0_src = SRC_CROSS;
    end else if (last_row && !c[0] && (c >= 11'd2)) begin
      s0_src = SRC_LAST_EVEN;
    end else if (last_row && c[0] && (c_inc == w_cl)) begin
      s0_src = SRC_LAST_ODD;
    end else begin
      s0_src = SRC_NONE;
    end

    case (s0_src)
      SRC_CROSS: begin
        s0_div    = (c_inc < w_cl) ? DIV_5 : DIV_4;
        s0_pos.ox = c[COL_W-1:1];
        s0_pos.oy = r[ROW_W-1:1] - 11'd1;
      end
      SRC_LAST_EVEN: begin
        s0_div    = DIV_4;
        s0_pos.ox = c[COL_W-1:1] - 10'd1;
        s0_pos.oy = r[ROW_W-1:1];
      end
      SRC_LAST_ODD: begin
        s0_div    = DIV_3;
        s0_pos.ox = c[COL_W-1:1];
        s0_pos.oy = r[ROW_W-1:1];
      end
      default: begin
        s0_div    = DIV_4;
        s0_pos.ox = c[COL_W-1:1];
        s0_pos.oy = r[ROW_W-1:1];
      end
    endcase
    s0_pos.last = ({1'b0, s0_pos.ox} == w_cl[CFG_W_W-1:1] - 11'd1)
               && ({1'b0, s0_pos.oy} == h_cl[CFG_H_W-1:1] - 12'd1);
  end

  // Advance position and recent pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rec0_q <= '0;
      rec1_q <= '0;
    end else if (in_accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      rec0_q <= px;
      rec1_q <= rec0_q;
    end
  end

  // Line buffers: row above and row two above
  cah_ram #(
    .WIDTH (NUM_CHAN * CHAN_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_above (
    .clk_i     (clk_i),
    .we_i      (s1_v_q),
    .waddr_i   (s1_q.col),
    .wdata_i   (s1_q.px),
    .raddr_a_i (c),
    .raddr_b_i (c + 11'd1),
    .rdata_a_o (ra_rd_a),
    .rdata_b_o (ra_rd_b)
  );

  cah_ram #(
    .WIDTH (NUM_CHAN * CHAN_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_two_above (
    .clk_i     (clk_i),
    .we_i      (s1_v_q),
    .waddr_i   (s1_q.col),
    .wdata_i   (above_c),
    .raddr_a_i (c),
    .raddr_b_i (c - 11'd1),
    .rdata_a_o (rt_rd_a),
    .rdata_b_o (rt_rd_b)
  );

  // Capture the item into the cross stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wr_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_accept;
      wr_v_q <= s1_v_q;
      s2_v_q <= s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.col  <= c;
      s1_q.px   <= px;
      s1_q.rec0 <= rec0_q;
      s1_q.rec1 <= rec1_q;
      s1_q.src  <= s0_src;
      s1_q.div  <= s0_div;
      s1_q.pos  <= s0_pos;
    end
    if (s1_v_q) begin
      wr_addr_q <= s1_q.col;
      wr_px_q   <= s1_q.px;
      wr_ab_q   <= above_c;
    end
    s2_pos_q <= s1_q.pos;
  end

  // Forward the write made at the edge the reads were sampled
  always_comb begin
    above_c = (wr_v_q && (wr_addr_q == s1_q.col)) ? wr_px_q : ra_rd_a;
    right_p = (wr_v_q && (wr_addr_q == s1_q.col + 11'd1)) ? wr_px_q : ra_rd_b;
    two_c   = (wr_v_q && (wr_addr_q == s1_q.col)) ? wr_ab_q : rt_rd_a;
    left_p  = (wr_v_q && (wr_addr_q == s1_q.col - 11'd1)) ? wr_ab_q : rt_rd_b;
  end

  // Select the cross neighbors, drop the missing ones
  always_comb begin
    case (s1_q.src)
      SRC_CROSS: begin
        op1 = above_c;
        op2 = two_c;
        op3 = left_p;
        op4 = (s1_q.div == DIV_5) ? right_p : '0;
      end
      SRC_LAST_EVEN: begin
        op1 = s1_q.rec0;
        op2 = s1_q.rec1;
        op3 = left_p;
        op4 = '0;
      end
      SRC_LAST_ODD: begin
        op1 = s1_q.rec0;
        op2 = above_c;
        op3 = '0;
        op4 = '0;
      end
      default: begin
        op1 = '0;
        op2 = '0;
        op3 = '0;
        op4 = '0;
      end
    endcase
    for (int k = 0; k < NUM_CHAN; k++) begin
      lane_opnd[k] = {op4[k], op3[k], op2[k], op1[k], s1_q.px[k]};
    end
  end

  // One lane per color channel
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    cah_lane u_lane (
      .clk_i  (clk_i),
      .opnd_i (lane_opnd[k]),
      .div_i  (s1_q.div),
      .avg_o  (lane_avg[k])
    );
  end

  // Merge lane results with the position into one item
  always_comb begin
    push_item.red   = lane_avg[2];
    push_item.green = lane_avg[1];
    push_item.blue  = lane_avg[0];
    push_item.pos   = s2_pos_q;
  end

  cah_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .item_i  (push_item),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .item_o  (head_item),
    .count_o (fifo_count)
  );

  assign red_out_o    = head_item.red;
  assign green_out_o  = head_item.green;
  assign blue_out_o   = head_item.blue;
  assign out_col_o    = head_item.pos.ox;
  assign out_row_o    = head_item.pos.oy;
  assign frame_last_o = head_item.pos.last;

  // Checks
  `CAH_ASSERT_IMPL(a_queue_no_overflow, clk_i, rst_ni, s2_v_q && out_stall_i,
                   fifo_count < OFIFO_CNT_W'(OFIFO_DEPTH))
  `CAH_ASSERT_NEXT(a_emit_reaches_queue, clk_i, rst_ni, in_accept && (s0_src != SRC_NONE),
                   ##1 s2_v_q)
  `CAH_ASSERT_IMPL(a_last_on_last_row, clk_i, rst_ni, out_valid_o && frame_last_o,
                   ({1'b0, out_row_o} == h_cl[CFG_H_W-1:1] - 12'd1))

endmodule

`default_nettype wire

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cah_pkg::*;

  // Register map: one 32-bit word per register
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 40;

  // Predicts the half-size pyramid level and holds the output pixels still to come
  class cross_mean_predictor;
    logic [23:0] row_prev [MAX_WIDTH];
    logic [23:0] row_prev2 [MAX_WIDTH];
    logic [23:0] newest_px, older_px;
    int unsigned col, row, width_reg, height_reg;
    int unsigned sum_r, sum_g, sum_b;
    out_item_t awaited [$];
    int failures;

    function new();
      foreach (row_prev[i]) begin
        row_prev[i] = '0;
        row_prev2[i] = '0;
      end
      newest_px = '0;
      older_px = '0;
      col = 0;
      row = 0;
      width_reg = 640;
      height_reg = 480;
      failures = 0;
    endfunction

    function void set_width(int unsigned v);
      width_reg = v % (1 << CFG_W_W);
    endfunction

    function void set_height(int unsigned v);
      height_reg = v % (1 << CFG_H_W);
    endfunction

    function int unsigned width_used();
      return width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    endfunction

    function int unsigned height_used();
      return height_reg < 2 ? 2 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    endfunction

    function void accumulate(logic [23:0] p);
      sum_r += p[23:16];
      sum_g += p[15:8];
      sum_b += p[7:0];
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        if (failures <= PRINT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // Advance the raster position by one source pixel and queue any output it completes
    function void take_source_pixel(chan_t r, chan_t g, chan_t b, bit restart);
      int unsigned w, h, c, rw, n, ox, oy;
      logic [23:0] px, up, up2;
      src_e kind;
      out_item_t item;
      w = width_used();
      h = height_used();
      px = {r, g, b};
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      n = 0;
      ox = 0;
      oy = 0;
      kind = SRC_NONE;

      if (restart) begin
        col = 0;
        row = 0;
      end
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      c = col;
      rw = row;
      up = row_prev[c];
      up2 = row_prev2[c];

      if (rw % 2 == 0 && rw >= 2 && c % 2 == 1) begin
        // Full cross centred one row up; drop the right arm at the edge
        accumulate(up);
        accumulate(up2);
        accumulate(row_prev2[c - 1]);
        accumulate(px);
        n = 4;
        if (c + 1 < w) begin
          accumulate(row_prev[c + 1]);
          n = 5;
        end
        kind = SRC_CROSS;
        ox = c >> 1;
        oy = (rw - 1) >> 1;
      end else if (h % 2 == 0 && rw == h - 1) begin
        // Bottom row of an even-height frame has no lower arm
        oy = rw >> 1;
        if (c % 2 == 0 && c >= 2) begin
          accumulate(newest_px);
          accumulate(older_px);
          accumulate(row_prev2[c - 1]);
          accumulate(px);
          n = 4;
          kind = SRC_LAST_EVEN;
          ox = (c - 1) >> 1;
        end else if (c % 2 == 1 && c == w - 1) begin
          accumulate(px);
          accumulate(newest_px);
          accumulate(up);
          n = 3;
          kind = SRC_LAST_ODD;
          ox = c >> 1;
        end
      end

      // Shift the line buffers and the recent pixels
      row_prev2[c] = up;
      row_prev[c] = px;
      older_px = newest_px;
      newest_px = px;
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row = rw + 1;
        if (row >= h) row = 0;
      end

      if (kind != SRC_NONE) begin
        item.red = chan_t'(sum_r / n);
        item.green = chan_t'(sum_g / n);
        item.blue = chan_t'(sum_b / n);
        item.pos.ox = 10'(ox);
        item.pos.oy = 11'(oy);
        item.pos.last = (ox == w / 2 - 1) && (oy == h / 2 - 1);
        awaited = {awaited, item};
      end
    endfunction

    // Check one output pixel against the oldest one awaited
    function void match_output(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= PRINT_LIMIT)
          $display("%0t: output pixel with none awaited, expected nothing, actual %h",
                   $time, got);
        return;
      end
      want = awaited.pop_front();
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("out_col", want.pos.ox, got.pos.ox);
      compare("out_row", want.pos.oy, got.pos.oy);
      compare("frame_last", want.pos.last, got.pos.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  chan_t       red_in = '0;
  chan_t       green_in = '0;
  chan_t       blue_in = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  chan_t       red_out, green_out, blue_out;
  logic [9:0]  out_col;
  logic [10:0] out_row;
  logic        frame_last;

  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int random_sent = 0;
  cross_mean_predictor pyramid = new();

  cross_average_half_downsample uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .frame_last_o (frame_last)
  );

  always #5 clk = ~clk;

  // Stall the output at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted output pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pyramid.match_output(out_item_t'({red_out, green_out, blue_out,
                                        out_col, out_row, frame_last}));
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic set_idling(int gap, int stall);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every awaited output is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pyramid.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both geometry registers while idle and read them back
  task automatic configure(int unsigned w_val, int unsigned h_val);
    logic [31:0] rd;
    settle();
    apb_write(ADDR_WIDTH, w_val);
    pyramid.set_width(w_val);
    apb_write(ADDR_HEIGHT, h_val);
    pyramid.set_height(h_val);
    apb_read(ADDR_WIDTH, rd);
    pyramid.compare("image_width readback", pyramid.width_reg, rd);
    apb_read(ADDR_HEIGHT, rd);
    pyramid.compare("image_height readback", pyramid.height_reg, rd);
  endtask

  // Offer one source pixel and hold it until accepted
  task automatic send_pixel(chan_t r, chan_t g, chan_t b, bit restart);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    frame_start <= restart;
    do @(posedge clk); while (in_stall);
    pyramid.take_source_pixel(r, g, b, restart);
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  // Stream random pixels from a frame start, with stray frame starts as noise
  task automatic stream(int unsigned count, int noise_pct);
    int unsigned i;
    for (i = 0; i < count; i++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(),
                 i == 0 || $urandom_range(99) < noise_pct);
  endtask

  initial begin
    logic [31:0] rd;
    int unsigned i, w_reg, h_reg, w, h;

    set_idling(20, 60);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers come out of reset at 640 x 480
    apb_read(ADDR_WIDTH, rd);
    pyramid.compare("image_width after reset", 640, rd);
    apb_read(ADDR_HEIGHT, rd);
    pyramid.compare("image_height after reset", 480, rd);

    // 4 x 4 frame: full and clipped crosses, bottom-row outputs, frame end
    configure(4, 4);
    for (i = 0; i < 16; i++)
      send_pixel(i % 2 ? 8'hFF : 8'h00, i % 3 ? 8'h00 : 8'hFF, chan_t'(i * 37 + 5), i == 0);
    // Next frame follows without a frame start
    for (i = 0; i < 7; i++)
      send_pixel(i % 2 ? 8'h00 : 8'hFF, chan_t'(200 - i * 29), i % 3 ? 8'hFF : 8'h00, 1'b0);
    // Width below range clamps to 2; the column counter jumps to the next row
    configure(1, 4);
    for (i = 0; i < 2; i++)
      send_pixel(8'hFF, 8'h80, chan_t'(i * 255), 1'b0);

    // Width above range clamps to the widest row, then the tallest frame
    configure(4095, 2);
    stream(40, 0);
    configure(3, 8191);
    stream(40, 0);

    // Random geometry, frames and partial frames under each idling mode
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3)
        set_idling(20, 60);
      else if (random_sent < 2 * RANDOM_ITEMS / 3)
        set_idling(60, 20);
      else
        set_idling(0, 0);
      case ($urandom_range(7))
        0: begin
          w_reg = $urandom_range(1);
          h_reg = $urandom_range(2, 8);
        end
        1: begin
          w_reg = $urandom_range(2, 8);
          h_reg = $urandom_range(1);
        end
        default: begin
          w_reg = $urandom_range(2, 9);
          h_reg = $urandom_range(2, 8);
        end
      endcase
      configure(w_reg, h_reg);
      w = pyramid.width_used();
      h = pyramid.height_used();
      i = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
      stream(i, 2);
      random_sent += i;
    end

    settle();
    if (pyramid.failures == 0 && pyramid.awaited.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
